>>> src/aes128_ctr_byte_stream_macros.svh
// Assertion helpers for the AES-128 CTR byte stream.
`ifndef AES128_CTR_BYTE_STREAM_MACROS_SVH
`define AES128_CTR_BYTE_STREAM_MACROS_SVH

// Implication checked at every clock, held off during reset.
`define ACTR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define ACTR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/actr_pkg.sv
`default_nettype none
package actr_pkg;

  localparam int unsigned BlkBytes = 16;
  localparam int unsigned Rounds   = 10;

  typedef enum logic [1:0] {
    CFG_KEY_LOW  = 2'd0,
    CFG_KEY_HIGH = 2'd1,
    CFG_NONCE    = 2'd2
  } cfg_idx_t;

  // one queued item, classified by the front end
  typedef struct packed {
    logic [7:0]  data;
    logic [3:0]  pos;
    logic [63:0] ctr;
    logic        need_ks;   // this byte needs a fresh keystream block
  } item_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a 128-bit block sits at [8*i +: 8]
  function automatic logic [127:0] round_fn(input logic [127:0] s, input logic [127:0] rk,
                                            input logic last);
    logic [127:0] t;
    logic [127:0] m;
    logic [7:0] a0, a1, a2, a3, al;
    t = '0;
    m = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[8*(r+4*c) +: 8] = sbox(s[8*(r + 4*((c+r) & 3)) +: 8]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[8*(4*c) +: 8];
      a1 = t[8*(4*c+1) +: 8];
      a2 = t[8*(4*c+2) +: 8];
      a3 = t[8*(4*c+3) +: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      m[8*(4*c) +: 8]   = a0 ^ al ^ xtime(a0 ^ a1);
      m[8*(4*c+1) +: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      m[8*(4*c+2) +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      m[8*(4*c+3) +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return (last ? t : m) ^ rk;
  endfunction

  function automatic logic [127:0] next_rk(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w;
    logic [127:0] n;
    w = {sbox(k[103:96]), sbox(k[127:120]), sbox(k[119:112]), sbox(k[111:104]) ^ rc};
    n[31:0]   = k[31:0]   ^ w;
    n[63:32]  = k[63:32]  ^ n[31:0];
    n[95:64]  = k[95:64]  ^ n[63:32];
    n[127:96] = k[127:96] ^ n[95:64];
    return n;
  endfunction

endpackage
`default_nettype wire

>>> src/aes128_ctr_byte_stream.sv
`default_nettype none
// AES-128 CTR byte masker. Each input beat carries one byte; each output beat
// returns it XORed with the keystream byte at the current offset. Counter block:
// nonce bytes 0..7, then 64-bit block counter bytes 8..15, both little-endian.
// A front end tracks counter and byte position and feeds a 4-entry queue; the
// back end masks one byte per cycle from a held keystream block, unless the
// output holds it back. A byte that starts a new block (restart, block wrap,
// after a config write or reset) stalls the back end while the iterative
// one-round-per-cycle AES core computes that block.
// Config writes are only allowed while no beat is in flight.
module aes128_ctr_byte_stream (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // data_byte[7:0], start_offset[31:0]
  input  wire logic        in_tuser,   // restart
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata   // out_byte
);
  import actr_pkg::*;

  logic [63:0] key_lo_r, key_hi_r, nonce_r;
  logic        flush;
  logic        q_valid, q_ready;
  item_t       q_item;

  assign flush = cfg_we && (cfg_index == CFG_KEY_LOW || cfg_index == CFG_KEY_HIGH ||
                            cfg_index == CFG_NONCE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_lo_r <= '0; key_hi_r <= '0; nonce_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_LOW:  key_lo_r <= cfg_data;
        CFG_KEY_HIGH: key_hi_r <= cfg_data;
        CFG_NONCE:    nonce_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  actr_front u_front (
    .clk, .rst_n, .flush,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .data_byte(in_tdata[7:0]), .restart(in_tuser), .start_offset(in_tdata[39:8]),
    .q_valid, .q_ready, .q_item
  );

  actr_back u_back (
    .clk, .rst_n, .key({key_hi_r, key_lo_r}), .nonce(nonce_r),
    .q_valid, .q_ready, .q_item,
    .out_valid(out_tvalid), .out_ready(out_tready), .out_byte(out_tdata)
  );
endmodule
`default_nettype wire

>>> src/actr_front.sv
`default_nettype none
module actr_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                flush,       // config write: next byte recomputes
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          data_byte,
  input  wire logic                restart,
  input  wire logic [31:0]         start_offset,
  output logic                     q_valid,
  input  wire logic                q_ready,
  output actr_pkg::item_t          q_item
);
  import actr_pkg::*;

  localparam int unsigned Depth = 4;

  item_t          mem_r [Depth];
  logic [1:0]     wp_r, rp_r;
  logic [2:0]     cnt_r;
  logic [63:0]    ctr_r;
  logic [3:0]     pos_r;
  logic           kv_r;
  item_t          it;
  logic           push, pop;

  assign in_ready = (cnt_r != 3'(Depth));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 3'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = mem_r[rp_r];

  always_comb begin
    it.data    = data_byte;
    it.pos     = restart ? start_offset[3:0] : pos_r;
    it.ctr     = restart ? {32'd0, 4'd0, start_offset[31:4]} : ctr_r;
    it.need_ks = restart || !kv_r;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= it;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
      ctr_r <= '0; pos_r <= '0; kv_r <= 1'b0;
    end else begin
      if (push) begin
        wp_r  <= wp_r + 2'd1;
        pos_r <= it.pos + 4'd1;
        ctr_r <= (it.pos == 4'd15) ? it.ctr + 64'd1 : it.ctr;
        kv_r  <= (it.pos != 4'd15);
      end
      if (flush) kv_r <= 1'b0;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'd0, push} - {2'd0, pop};
    end
  end

  `include "aes128_ctr_byte_stream_macros.svh"
  `ACTR_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= 3'(Depth), "queue count over depth")
  `ACTR_ASSERT_NXT(a_wrap_inval, push && it.pos == 4'd15 && !flush, !kv_r, "wrap kept keystream")
  `ACTR_ASSERT_NXT(a_flush, flush, !kv_r, "config write kept keystream")
endmodule
`default_nettype wire

>>> src/actr_back.sv
`default_nettype none
module actr_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [127:0]        key,
  input  wire logic [63:0]         nonce,
  input  wire logic                q_valid,
  output logic                     q_ready,
  input  actr_pkg::item_t          q_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               out_byte
);
  import actr_pkg::*;

  logic [127:0] st_r, rk_r, ks_r;
  logic [3:0]   rnd_r;       // 0 idle, 1..10 rounds in flight
  logic [7:0]   rc_r;
  logic         busy;
  logic         ov_r;
  logic [7:0]   ob_r;
  logic         kd_r;        // fresh block done for the byte at the queue head
  logic [127:0] rk_n;
  logic         take;

  assign busy     = (rnd_r != 4'd0);
  assign rk_n     = next_rk(rk_r, rc_r);
  // a queued byte that needs a new block waits for the cipher; others mask directly
  assign q_ready  = !busy && (!ov_r || out_ready) && (!q_item.need_ks || kd_r);
  assign take     = q_valid && q_ready;
  assign out_valid = ov_r;
  assign out_byte  = ob_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_r <= '0; ov_r <= 1'b0; kd_r <= 1'b0;
    end else begin
      if (ov_r && out_ready) ov_r <= 1'b0;
      if (!busy && q_valid && q_item.need_ks && !kd_r) begin
        st_r  <= {q_item.ctr, nonce} ^ key;
        rk_r  <= key;
        rc_r  <= 8'h01;
        rnd_r <= 4'd1;
      end else if (busy) begin
        st_r  <= round_fn(st_r, rk_n, rnd_r == 4'(Rounds));
        rk_r  <= rk_n;
        rc_r  <= xtime(rc_r);
        rnd_r <= (rnd_r == 4'(Rounds)) ? 4'd0 : rnd_r + 4'd1;
        if (rnd_r == 4'(Rounds)) begin
          ks_r <= round_fn(st_r, rk_n, 1'b1);
          kd_r <= 1'b1;
        end
      end
      if (take) begin
        ob_r <= q_item.data ^ ks_r[8*q_item.pos +: 8];
        ov_r <= 1'b1;
        kd_r <= 1'b0;
      end
    end
  end

  `include "aes128_ctr_byte_stream_macros.svh"
  `ACTR_ASSERT_IMP(a_no_take_busy, busy, !take, "byte taken during cipher")
  `ACTR_ASSERT_IMP(a_rnd_bound, 1'b1, rnd_r <= 4'(Rounds), "round count out of range")
  `ACTR_ASSERT_NXT(a_hold, ov_r && !out_ready, ov_r && $stable(ob_r), "output dropped")
endmodule
`default_nettype wire

>>> dv/aes128_ctr_byte_stream_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module aes128_ctr_byte_stream_tb;
  import actr_pkg::*;

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned RandItems = 1030;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [39:0] in_tdata = '0;   // data_byte[7:0], start_offset[31:0]
  logic in_tuser = 1'b0;        // restart
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  aes128_ctr_byte_stream dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata
  );

  // predictor state: registers plus keystream position
  logic [63:0] pk_key_lo, pk_key_hi, pk_nonce;
  logic [63:0] pk_ctr;
  logic [3:0] pk_pos;
  logic [127:0] pk_ks;
  logic pk_ks_ok;

  logic [7:0] masked_q[$];
  int unsigned err_cnt = 0;
  int unsigned idle_cnt = 0;
  bit quiet_out = 1'b0;

  // plain S-box built from GF(2^8) inverse + affine map
  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  function automatic logic [7:0] sub_byte(input logic [7:0] x);
    logic [7:0] inv, r;
    inv = 8'h00;
    if (x != 0) begin
      inv = x;
      // x^254
      for (int i = 0; i < 6; i++) inv = gmul(gmul(inv, inv), x);
      inv = gmul(inv, inv);
    end
    r = 8'h63;
    for (int i = 0; i < 8; i++)
      r[i] = r[i] ^ inv[i] ^ inv[(i+4)%8] ^ inv[(i+5)%8] ^ inv[(i+6)%8] ^ inv[(i+7)%8];
    return r;
  endfunction

  function automatic logic [127:0] encrypt_block(input logic [127:0] blk,
                                                 input logic [127:0] key);
    logic [7:0] rk[176];
    logic [7:0] s[16], t[16], tmp[4], f, a0, a1, a2, a3, al, rc;
    for (int i = 0; i < 16; i++) rk[i] = key[8*i +: 8];
    rc = 8'h01;
    for (int i = 4; i < 44; i++) begin
      for (int j = 0; j < 4; j++) tmp[j] = rk[4*(i-1)+j];
      if ((i & 3) == 0) begin
        f = tmp[0];
        tmp[0] = sub_byte(tmp[1]) ^ rc;
        tmp[1] = sub_byte(tmp[2]);
        tmp[2] = sub_byte(tmp[3]);
        tmp[3] = sub_byte(f);
        rc = gmul(rc, 8'h02);
      end
      for (int j = 0; j < 4; j++) rk[4*i+j] = rk[4*(i-4)+j] ^ tmp[j];
    end
    for (int i = 0; i < 16; i++) s[i] = blk[8*i +: 8] ^ rk[i];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) t[r+4*c] = sub_byte(s[r+4*((c+r)&3)]);
      if (rnd != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ al ^ gmul(a0 ^ a1, 8'h02);
          t[4*c+1] = a1 ^ al ^ gmul(a1 ^ a2, 8'h02);
          t[4*c+2] = a2 ^ al ^ gmul(a2 ^ a3, 8'h02);
          t[4*c+3] = a3 ^ al ^ gmul(a3 ^ a0, 8'h02);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16*rnd+i];
    end
    for (int i = 0; i < 16; i++) encrypt_block[8*i +: 8] = s[i];
  endfunction

  // advance the keystream by one byte and return the masked byte
  function automatic logic [7:0] mask_byte(input logic [7:0] d, input logic rs,
                                           input logic [31:0] ofs);
    logic [7:0] r;
    if (rs) begin
      pk_ctr = {36'd0, ofs[31:4]};
      pk_pos = ofs[3:0];
      pk_ks_ok = 1'b0;
    end
    if (!pk_ks_ok) begin
      pk_ks = encrypt_block({pk_ctr, pk_nonce}, {pk_key_hi, pk_key_lo});
      pk_ks_ok = 1'b1;
    end
    r = d ^ pk_ks[8*pk_pos +: 8];
    pk_pos = pk_pos + 4'd1;
    if (pk_pos == 0) begin
      pk_ctr = pk_ctr + 64'd1;
      pk_ks_ok = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    err_cnt++;
    $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  // output side: random backpressure (none while quiet_out), compare against oldest expectation
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (masked_q.size() == 0)
          report_mismatch($sformatf("unexpected beat %02h", out_tdata));
        else if (out_tdata !== masked_q[0]) begin
          report_mismatch($sformatf("out_byte got %02h want %02h", out_tdata, masked_q[0]));
          void'(masked_q.pop_front());
        end else
          void'(masked_q.pop_front());
      end
      out_tready <= quiet_out ? 1'b1 : ($urandom_range(99) >= 11);
    end
  end

  // watchdog: cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cnt <= 0;
    else if (rst_n && (in_tvalid || masked_q.size() != 0)) idle_cnt <= idle_cnt + 1;
    if (idle_cnt > StallLimit) begin
      $display("aes128_ctr_byte_stream_tb NOT OK");
      $finish;
    end
  end

  // block is idle when every beat came back and the pipeline has drained
  task automatic wait_idle();
    while (masked_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_KEY_LOW:  pk_key_lo = val;
      CFG_KEY_HIGH: pk_key_hi = val;
      CFG_NONCE:    pk_nonce = val;
      default: ;
    endcase
    pk_ks_ok = 1'b0;
    @(posedge clk);
  endtask

  // one input beat; keeps valid up between back-to-back beats
  task automatic send_beat(input logic [7:0] d, input logic rs, input logic [31:0] ofs,
                           input bit gappy);
    if (gappy) begin
      while ($urandom_range(99) < 11) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata <= {ofs, d};
    in_tuser <= rs;
    masked_q.push_back(mask_byte(d, rs, ofs));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  typedef struct {
    logic [7:0] d;
    logic rs;
    logic [31:0] ofs;
  } beat_row_t;

  // directed rows: extremes, restarts mid-block, counter wrap at top offset
  beat_row_t dir_rows[16] = '{
    '{8'h00, 1'b0, 32'h0},          '{8'hff, 1'b0, 32'hffff_ffff},
    '{8'h5a, 1'b0, 32'h0},          '{8'ha5, 1'b1, 32'h0000_0000},
    '{8'h01, 1'b1, 32'h0000_000f},  '{8'h80, 1'b0, 32'h0},
    '{8'h7f, 1'b1, 32'hffff_fffe},  '{8'hff, 1'b0, 32'h0},
    '{8'h00, 1'b0, 32'h0},          '{8'h3c, 1'b1, 32'h8000_0007},
    '{8'hc3, 1'b1, 32'hffff_ffff},  '{8'h11, 1'b0, 32'h0},
    '{8'h22, 1'b1, 32'h0000_0010},  '{8'h44, 1'b0, 32'h5555_5555},
    '{8'h88, 1'b1, 32'haaaa_aaaa},  '{8'hee, 1'b0, 32'h0}
  };

  initial begin
    logic [31:0] ofs;
    int unsigned run_len;
    bit gappy;
    pk_key_lo = '0; pk_key_hi = '0; pk_nonce = '0;
    pk_ctr = '0; pk_pos = '0; pk_ks = '0; pk_ks_ok = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // keystream straight out of reset, all-zero key and nonce
    foreach (dir_rows[i]) send_beat(dir_rows[i].d, dir_rows[i].rs, dir_rows[i].ofs, 1'b1);
    in_tvalid <= 1'b0;
    wait_idle();

    // all-ones registers, keep counter position across the write
    write_reg(CFG_KEY_LOW, '1);
    write_reg(CFG_KEY_HIGH, '1);
    write_reg(CFG_NONCE, '1);
    for (int i = 0; i < 20; i++) send_beat(8'(i * 13), 1'b0, 32'h0, 1'b1);
    in_tvalid <= 1'b0;
    wait_idle();

    // random phases with fresh settings; one phase without idling
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_KEY_LOW, {$urandom, $urandom});
      write_reg(CFG_KEY_HIGH, {$urandom, $urandom});
      write_reg(CFG_NONCE, (ph == 4) ? 64'h0 : {$urandom, $urandom});
      quiet_out = (ph == 2);
      gappy = (ph != 2);
      for (int n = 0; n < RandItems / 5; ) begin
        // messages: restart then a mostly contiguous run with rare extra restarts, random content
        ofs = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(200));
        run_len = $urandom_range(1, 40);
        for (int k = 0; k < run_len && n < RandItems / 5; k++, n++)
          send_beat(8'($urandom), (k == 0) || ($urandom_range(99) < 3), k == 0 ? ofs : $urandom,
                    gappy);
      end
      in_tvalid <= 1'b0;
      wait_idle();
    end
    quiet_out = 1'b0;

    wait_idle();
    if (err_cnt == 0) $display("aes128_ctr_byte_stream_tb OK");
    else $display("aes128_ctr_byte_stream_tb NOT OK");
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
+incdir+src
src/actr_pkg.sv
src/actr_front.sv
src/actr_back.sv
src/aes128_ctr_byte_stream.sv
dv/aes128_ctr_byte_stream_tb.sv
